FILE: rtl/text_line_normalizer_core_assert.svh
// Assertion macros for the text line normalizer RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef TEXT_LINE_NORMALIZER_CORE_ASSERT_SVH
`define TEXT_LINE_NORMALIZER_CORE_ASSERT_SVH

// Same-cycle implication.
`define TLN_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tln assertion failed");

// Next-cycle implication.
`define TLN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tln assertion failed");

`endif

FILE: rtl/tlnorm_pkg.sv
// Shared types, constants and character helpers for the text line normalizer.
// No dependencies.
package tlnorm_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int HOLD_MAX        = 12;
    localparam int HOLD_IDX_W      = 4;
    localparam int CAP_W           = 25;
    localparam int TOTAL_W         = 24;
    localparam logic [CAP_W-1:0] CAP_RESET = 25'd4096;
    localparam int ADDR_W          = 3;
    localparam logic [0:0] REG_CAPACITY = 1'b0;

    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_END     = 1'b1;
    localparam logic KIND_TEXT   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [1:0] MODE_SKIP   = 2'd0;
    localparam logic [1:0] MODE_HOLD   = 2'd1;
    localparam logic [1:0] MODE_STREAM = 2'd2;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  text_byte;
        logic        status;
        logic [23:0] total_length;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE, OP_LATCH, OP_SET_BLANK, OP_WS, OP_START_HOLD, OP_NL1, OP_NL2,
        OP_HOLD_EMIT, OP_PEND_SP, OP_EMIT_B, OP_FILL_SP, OP_FILL_B, OP_END_CLR,
        OP_REPORT, OP_FLUSH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic       item_end;
        logic       item_nl;
        logic       item_ws;
        logic [1:0] mode;
        logic       page_like;
        logic       need_ok;
        logic       pend_nz;
        logic       pend_one;
        logic       hold_last;
        logic       stage_busy;
    } t_dp_status;

    function automatic logic is_ws(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0C || c == 8'h0B;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [7:0] page_char(input logic [1:0] i);
        logic [7:0] r;
        unique case (i)
            2'd0: r = 8'h70;
            2'd1: r = 8'h61;
            2'd2: r = 8'h67;
            default: r = 8'h65;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
    endfunction

endpackage

FILE: rtl/tlnorm_ctrl.sv
// Normalizer sequencer: one micro-step per cycle unless stalled.
// Depends on tlnorm_pkg.
module tlnorm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  tlnorm_pkg::t_dp_status i_status,
    output tlnorm_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_NL1, ST_NL2, ST_HOLD_EMIT, ST_PEND_SP, ST_EMIT_B,
        ST_FILL_SP, ST_FILL_B, ST_END_CLR, ST_REPORT, ST_FINISH
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = tlnorm_pkg::OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = tlnorm_pkg::OP_LATCH;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_status.item_end || i_status.item_nl) begin
                    if (i_status.mode == tlnorm_pkg::MODE_HOLD) begin
                        n_state = i_status.page_like ? ST_END_CLR : ST_NL1;
                    end else if (i_status.mode == tlnorm_pkg::MODE_STREAM) begin
                        n_state = ST_END_CLR;
                    end else begin
                        o_cmd.op = tlnorm_pkg::OP_SET_BLANK;
                        n_state  = ST_END_CLR;
                    end
                end else if (i_status.item_ws) begin
                    o_cmd.op = tlnorm_pkg::OP_WS;
                    n_state  = ST_FINISH;
                end else if (i_status.mode == tlnorm_pkg::MODE_HOLD) begin
                    if (i_status.need_ok) begin
                        n_state = i_status.pend_nz ? ST_FILL_SP : ST_FILL_B;
                    end else begin
                        n_state = ST_NL1;
                    end
                end else if (i_status.mode == tlnorm_pkg::MODE_STREAM) begin
                    n_state = i_status.pend_nz ? ST_PEND_SP : ST_EMIT_B;
                end else begin
                    o_cmd.op = tlnorm_pkg::OP_START_HOLD;
                    n_state  = ST_FINISH;
                end
            end
            ST_NL1: begin
                if (!i_status.stage_busy) begin
                    o_cmd.op = tlnorm_pkg::OP_NL1;
                    n_state  = ST_NL2;
                end
            end
            ST_NL2: begin
                if (!i_status.stage_busy) begin
                    o_cmd.op = tlnorm_pkg::OP_NL2;
                    n_state  = ST_HOLD_EMIT;
                end
            end
            ST_HOLD_EMIT: begin
                if (!i_status.stage_busy) begin
                    o_cmd.op = tlnorm_pkg::OP_HOLD_EMIT;
                    if (i_status.hold_last) begin
                        if (i_status.item_end || i_status.item_nl) begin
                            n_state = ST_END_CLR;
                        end else begin
                            n_state = i_status.pend_nz ? ST_PEND_SP : ST_EMIT_B;
                        end
                    end
                end
            end
            ST_PEND_SP: begin
                if (!i_status.stage_busy) begin
                    o_cmd.op = tlnorm_pkg::OP_PEND_SP;
                    n_state  = ST_EMIT_B;
                end
            end
            ST_EMIT_B: begin
                if (!i_status.stage_busy) begin
                    o_cmd.op = tlnorm_pkg::OP_EMIT_B;
                    n_state  = ST_FINISH;
                end
            end
            ST_FILL_SP: begin
                o_cmd.op = tlnorm_pkg::OP_FILL_SP;
                if (i_status.pend_one) begin
                    n_state = ST_FILL_B;
                end
            end
            ST_FILL_B: begin
                o_cmd.op = tlnorm_pkg::OP_FILL_B;
                n_state  = ST_FINISH;
            end
            ST_END_CLR: begin
                o_cmd.op = tlnorm_pkg::OP_END_CLR;
                n_state  = i_status.item_end ? ST_REPORT : ST_FINISH;
            end
            ST_REPORT: begin
                if (!i_status.stage_busy) begin
                    o_cmd.op = tlnorm_pkg::OP_REPORT;
                    n_state  = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_status.stage_busy) begin
                    o_cmd.op = tlnorm_pkg::OP_FLUSH;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

FILE: rtl/tlnorm_dp.sv
// Datapath for the text line normalizer: hold buffer, line state, counters,
// one-deep result stage and output register. Depends on tlnorm_pkg and the macros.
`include "text_line_normalizer_core_assert.svh"

module tlnorm_dp #(
    parameter int LENGTH_BITS = tlnorm_pkg::LENGTH_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tlnorm_pkg::t_in_item          i_in,
    input  logic [tlnorm_pkg::CAP_W-1:0]  i_capacity,
    input  tlnorm_pkg::t_dp_cmd           i_cmd,
    output tlnorm_pkg::t_dp_status        o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tlnorm_pkg::t_out_item         o_out
);

    localparam int HW = tlnorm_pkg::HOLD_IDX_W;
    localparam int CW = 33;

    tlnorm_pkg::t_in_item r_item;
    logic [7:0]  r_hold [tlnorm_pkg::HOLD_MAX];
    logic [HW-1:0] r_count, r_pend, r_idx;
    logic [1:0]  r_mode;
    logic        r_blank, r_wrote, r_ovf, r_prev;
    logic [LENGTH_BITS-1:0] r_wc;
    logic        r_pfx, r_rest_ok, r_rest_dig, r_alt_ok;
    logic [2:0]  r_dcnt;
    logic        r_stg_valid, r_out_valid;
    tlnorm_pkg::t_out_item r_stg, r_out;

    // write limit
    logic [tlnorm_pkg::CAP_W-1:0] cap_c;
    logic [CW-1:0] lim, maxlen, wc_ext;
    logic at_limit;

    always_comb begin
        if (i_capacity == '0) begin
            cap_c = 25'd1;
        end else if (i_capacity > 25'h1000000) begin
            cap_c = 25'h1000000;
        end else begin
            cap_c = i_capacity;
        end
        lim    = CW'(cap_c - 25'd1);
        maxlen = (CW'(1) << LENGTH_BITS) - CW'(1);
        if (lim > maxlen) begin
            lim = maxlen;
        end
        wc_ext   = CW'(r_wc);
        at_limit = (wc_ext >= lim);
    end

    // emit request decode
    logic       emit_req;
    logic [7:0] emit_byte;
    logic [7:0] hc;
    logic       hc_ws;

    assign hc    = r_hold[r_idx];
    assign hc_ws = tlnorm_pkg::is_ws(hc);

    always_comb begin
        emit_req  = 1'b0;
        emit_byte = tlnorm_pkg::CH_SPACE;
        unique case (i_cmd.op)
            tlnorm_pkg::OP_NL1: begin
                emit_req  = r_wrote;
                emit_byte = tlnorm_pkg::CH_NL;
            end
            tlnorm_pkg::OP_NL2: begin
                emit_req  = r_wrote && r_blank;
                emit_byte = tlnorm_pkg::CH_NL;
            end
            tlnorm_pkg::OP_HOLD_EMIT: begin
                emit_req  = !(hc_ws && r_prev);
                emit_byte = hc_ws ? tlnorm_pkg::CH_SPACE : hc;
            end
            tlnorm_pkg::OP_PEND_SP: begin
                emit_req = 1'b1;
            end
            tlnorm_pkg::OP_EMIT_B: begin
                emit_req  = 1'b1;
                emit_byte = r_item.data_byte;
            end
            default: ;
        endcase
    end

    logic push_text, set_ovf, push_rep, push_any, flush;
    logic [LENGTH_BITS-1:0] wc_inc;
    logic [LENGTH_BITS+tlnorm_pkg::TOTAL_W-1:0] tot_text, tot_rep;
    tlnorm_pkg::t_out_item new_res;
    tlnorm_pkg::t_out_item out_next;

    assign push_text = emit_req && !r_ovf && !at_limit;
    assign set_ovf   = emit_req && !r_ovf && at_limit;
    assign push_rep  = (i_cmd.op == tlnorm_pkg::OP_REPORT);
    assign push_any  = push_text || push_rep;
    assign flush     = (i_cmd.op == tlnorm_pkg::OP_FLUSH);
    assign wc_inc    = r_wc + LENGTH_BITS'(1);
    assign tot_text  = {{tlnorm_pkg::TOTAL_W{1'b0}}, wc_inc};
    assign tot_rep   = {{tlnorm_pkg::TOTAL_W{1'b0}}, r_wc};

    always_comb begin
        new_res.last = 1'b0;
        if (push_rep) begin
            new_res.kind         = tlnorm_pkg::KIND_REPORT;
            new_res.text_byte    = 8'h00;
            new_res.status       = r_ovf;
            new_res.total_length = tot_rep[tlnorm_pkg::TOTAL_W-1:0];
        end else begin
            new_res.kind         = tlnorm_pkg::KIND_TEXT;
            new_res.text_byte    = emit_byte;
            new_res.status       = 1'b0;
            new_res.total_length = tot_text[tlnorm_pkg::TOTAL_W-1:0];
        end
    end

    // staged result on its way out; last only on the item's closing step
    always_comb begin
        out_next      = r_stg;
        out_next.last = flush;
    end

    // page-line tracking for the appended byte
    logic [7:0] app_c;
    logic       app_dig, app_rest, app_alt, app_pfx;
    logic [4:0] need;

    assign app_c    = (i_cmd.op == tlnorm_pkg::OP_FILL_SP) ? tlnorm_pkg::CH_SPACE
                                                           : r_item.data_byte;
    assign app_dig  = tlnorm_pkg::is_digit(app_c);
    assign app_rest = app_dig || tlnorm_pkg::is_ws(app_c) || app_c == tlnorm_pkg::CH_DASH
                      || app_c == tlnorm_pkg::CH_DOT;
    assign app_alt  = app_dig || tlnorm_pkg::is_ws(app_c) || app_c == tlnorm_pkg::CH_DASH
                      || app_c == tlnorm_pkg::CH_SLASH || app_c == tlnorm_pkg::CH_BAR;
    assign app_pfx  = tlnorm_pkg::to_lower(app_c) == tlnorm_pkg::page_char(r_count[1:0]);
    assign need     = 5'(r_count) + 5'(r_pend) + 5'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == tlnorm_pkg::OP_LATCH) begin
            r_item <= i_in;
        end
        if (i_cmd.op == tlnorm_pkg::OP_START_HOLD) begin
            r_hold[0] <= r_item.data_byte;
        end
        if (i_cmd.op == tlnorm_pkg::OP_FILL_SP || i_cmd.op == tlnorm_pkg::OP_FILL_B) begin
            r_hold[r_count] <= app_c;
        end
        if (push_any) begin
            r_stg <= new_res;
        end
        if ((push_any || flush) && r_stg_valid) begin
            r_out <= out_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= '0;
            r_idx       <= '0;
            r_mode      <= tlnorm_pkg::MODE_SKIP;
            r_blank     <= 1'b0;
            r_wrote     <= 1'b0;
            r_ovf       <= 1'b0;
            r_prev      <= 1'b0;
            r_wc        <= '0;
            r_pfx       <= 1'b0;
            r_rest_ok   <= 1'b0;
            r_rest_dig  <= 1'b0;
            r_alt_ok    <= 1'b0;
            r_dcnt      <= '0;
            r_stg_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (push_text) begin
                r_wc    <= wc_inc;
                r_wrote <= 1'b1;
            end
            if (set_ovf) begin
                r_ovf <= 1'b1;
            end
            unique case (i_cmd.op)
                tlnorm_pkg::OP_SET_BLANK: r_blank <= 1'b1;
                tlnorm_pkg::OP_WS: begin
                    if (r_mode == tlnorm_pkg::MODE_HOLD) begin
                        if (r_pend < HW'(tlnorm_pkg::HOLD_MAX)) begin
                            r_pend <= r_pend + HW'(1);
                        end
                    end else if (r_mode == tlnorm_pkg::MODE_STREAM) begin
                        r_pend <= HW'(1);
                    end
                end
                tlnorm_pkg::OP_START_HOLD: begin
                    r_count    <= HW'(1);
                    r_pend     <= '0;
                    r_mode     <= tlnorm_pkg::MODE_HOLD;
                    r_pfx      <= app_pfx;
                    r_rest_ok  <= 1'b1;
                    r_rest_dig <= 1'b0;
                    r_alt_ok   <= app_alt;
                    r_dcnt     <= {2'b00, app_dig};
                end
                tlnorm_pkg::OP_FILL_SP, tlnorm_pkg::OP_FILL_B: begin
                    r_count <= r_count + HW'(1);
                    if (i_cmd.op == tlnorm_pkg::OP_FILL_SP) begin
                        r_pend <= r_pend - HW'(1);
                    end
                    if (r_count < HW'(4)) begin
                        r_pfx <= r_pfx && app_pfx;
                    end else begin
                        r_rest_ok  <= r_rest_ok && app_rest;
                        r_rest_dig <= r_rest_dig || app_dig;
                    end
                    r_alt_ok <= r_alt_ok && app_alt;
                    if (app_dig && r_dcnt < 3'd5) begin
                        r_dcnt <= r_dcnt + 3'd1;
                    end
                end
                tlnorm_pkg::OP_NL2: begin
                    r_blank <= 1'b0;
                    r_idx   <= '0;
                    r_prev  <= 1'b0;
                end
                tlnorm_pkg::OP_HOLD_EMIT: begin
                    r_idx <= r_idx + HW'(1);
                    if (!(hc_ws && r_prev)) begin
                        r_prev <= hc_ws;
                    end
                end
                tlnorm_pkg::OP_EMIT_B: begin
                    r_pend  <= '0;
                    r_count <= '0;
                    r_mode  <= tlnorm_pkg::MODE_STREAM;
                end
                tlnorm_pkg::OP_END_CLR: begin
                    r_count <= '0;
                    r_pend  <= '0;
                    r_mode  <= tlnorm_pkg::MODE_SKIP;
                end
                tlnorm_pkg::OP_REPORT: begin
                    r_count <= '0;
                    r_pend  <= '0;
                    r_mode  <= tlnorm_pkg::MODE_SKIP;
                    r_blank <= 1'b0;
                    r_wrote <= 1'b0;
                    r_wc    <= '0;
                    r_ovf   <= 1'b0;
                end
                default: ;
            endcase

            // result stage and output register
            if (push_any) begin
                r_stg_valid <= 1'b1;
            end else if (flush) begin
                r_stg_valid <= 1'b0;
            end
            if ((push_any || flush) && r_stg_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    logic mode_hold;
    assign mode_hold = (r_mode == tlnorm_pkg::MODE_HOLD);

    always_comb begin
        o_status.item_end   = (r_item.cmd == tlnorm_pkg::CMD_END);
        o_status.item_nl    = (r_item.cmd == tlnorm_pkg::CMD_DATA)
                              && (r_item.data_byte == tlnorm_pkg::CH_NL);
        o_status.item_ws    = (r_item.cmd == tlnorm_pkg::CMD_DATA)
                              && tlnorm_pkg::is_ws(r_item.data_byte);
        o_status.mode       = r_mode;
        o_status.page_like  = (r_count >= HW'(4) && r_pfx && r_rest_ok && r_rest_dig)
                              || (r_alt_ok && r_dcnt >= 3'd1 && r_dcnt <= 3'd4);
        o_status.need_ok    = need <= 5'(tlnorm_pkg::HOLD_MAX);
        o_status.pend_nz    = (r_pend != '0);
        o_status.pend_one   = (r_pend == HW'(1));
        o_status.hold_last  = (r_idx == r_count - HW'(1));
        o_status.stage_busy = r_stg_valid && r_out_valid && i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `TLN_ASSERT_NOW(a_hold_bound, mode_hold, r_count <= HW'(tlnorm_pkg::HOLD_MAX))
    `TLN_ASSERT_NOW(a_text_ok, r_out_valid && r_out.kind == tlnorm_pkg::KIND_TEXT, !r_out.status)
    `TLN_ASSERT_NOW(a_wc_limit, 1'b1, wc_ext <= maxlen)
    `TLN_ASSERT_NEXT(a_ovf_sticky, r_ovf && i_cmd.op != tlnorm_pkg::OP_REPORT, r_ovf)

endmodule

FILE: rtl/text_line_normalizer_core.sv
// Text line normalizer: one item at a time; the input stays stalled until the item's steps
// are done, fewest for whitespace or a new hold, more for a streamed byte or plain line end,
// more again with a pending space or for a held byte with pending spaces, and most for an
// item that flushes a full 12-byte hold. A result waits in a stage until the next result
// or the item's closing step so its last flag is known; output stalls can hold the sequencer.
// Synchronous active-low reset clears all stream state; the capacity register resets to 4096.
module text_line_normalizer_core #(
    parameter int LENGTH_BITS = tlnorm_pkg::LENGTH_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input requests
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  tlnorm_pkg::t_in_item             i_in,
    // result requests
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output tlnorm_pkg::t_out_item            o_out,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tlnorm_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    // capacity register lives at byte address 0 (only address bit 2 is decoded, so 1 to 3 alias it); 4 to 7 read zero.
    logic [tlnorm_pkg::CAP_W-1:0] r_capacity;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= tlnorm_pkg::CAP_RESET;
        end else if (cfg_wr && paddr[2] == tlnorm_pkg::REG_CAPACITY) begin
            r_capacity <= pwdata[tlnorm_pkg::CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == tlnorm_pkg::REG_CAPACITY) ? 32'(r_capacity) : 32'd0;

    // controller and datapath talk only through command and status
    tlnorm_pkg::t_dp_cmd    dp_cmd;
    tlnorm_pkg::t_dp_status dp_status;

    tlnorm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    tlnorm_dp #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_capacity  (r_capacity),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_line_normalizer_core: directed and random byte streams.
// Depends on tlnorm_pkg and the core RTL; predicts results with its own line-trim model.
module tb_top;

    localparam int HOLD_LEN = 12;
    localparam int N_DIRECTED = 24;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    tlnorm_pkg::t_in_item  i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    tlnorm_pkg::t_out_item o_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [tlnorm_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    text_line_normalizer_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor state: a private copy of the normalizer's line state.
    // ---------------------------------------------------------------
    logic [7:0]  hold_q [HOLD_LEN];
    int          hold_n;
    int          pend_sp;
    logic [1:0]  mode_q;
    bit          blank_q;
    bit          wrote_q;
    logic [23:0] written_q;
    bit          ovf_q;
    logic [24:0] cap_q;

    tlnorm_pkg::t_out_item expected_results[$];
    tlnorm_pkg::t_out_item burst[$];
    int          n_errors = 0;
    int          n_sent = 0;

    function automatic bit ws_char(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0C || c == 8'h0B;
    endfunction

    function automatic bit digit_char(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Bytes allowed per stream: capacity-1, zero capacity acting as one,
    // capped at 2^24 capacity.
    function automatic logic [24:0] byte_limit();
        logic [24:0] c;
        c = cap_q;
        if (c == 0) c = 1;
        if (c > 25'd16777216) c = 25'd16777216;
        return c - 1;
    endfunction

    function automatic void push_text(logic [7:0] b);
        tlnorm_pkg::t_out_item r;
        if (ovf_q) return;
        if ({1'b0, written_q} >= byte_limit()) begin
            ovf_q = 1'b1;
            return;
        end
        written_q++;
        wrote_q = 1'b1;
        r = '0;
        r.kind = tlnorm_pkg::KIND_TEXT;
        r.text_byte = b;
        r.total_length = written_q;
        burst.push_back(r);
    endfunction

    function automatic bit hold_is_page_number();
        bit hit, ok, dig;
        int digits;
        logic [7:0] c;
        logic [31:0] word;
        word = "page";
        if (hold_n == 0) return 0;
        if (hold_n >= 4) begin
            hit = 1;
            for (int i = 0; i < 4; i++) begin
                c = hold_q[i];
                if (c >= "A" && c <= "Z") c = c + 8'd32;
                if (c != word[8*(3-i) +: 8]) hit = 0;
            end
            if (hit) begin
                ok = 1;
                dig = 0;
                for (int i = 4; i < hold_n; i++) begin
                    c = hold_q[i];
                    if (digit_char(c)) dig = 1;
                    else if (!ws_char(c) && c != "-" && c != ".") ok = 0;
                end
                if (ok && dig) return 1;
            end
        end
        digits = 0;
        for (int i = 0; i < hold_n; i++) begin
            c = hold_q[i];
            if (digit_char(c)) digits++;
            else if (!ws_char(c) && c != "-" && c != "/" && c != "|") return 0;
        end
        return digits >= 1 && digits <= 4;
    endfunction

    // Line separator before new content: one newline, two after blank lines, none before the first written byte.
    function automatic void open_content_line();
        if (wrote_q) begin
            push_text(tlnorm_pkg::CH_NL);
            if (blank_q) push_text(tlnorm_pkg::CH_NL);
        end
        blank_q = 0;
    endfunction

    function automatic void flush_hold();
        bit prev;
        prev = 0;
        for (int i = 0; i < hold_n; i++) begin
            if (ws_char(hold_q[i])) begin
                if (!prev) push_text(tlnorm_pkg::CH_SPACE);
                prev = 1;
            end else begin
                prev = 0;
                push_text(hold_q[i]);
            end
        end
    endfunction

    function automatic void close_line();
        if (mode_q == tlnorm_pkg::MODE_HOLD) begin
            if (!hold_is_page_number()) begin
                open_content_line();
                flush_hold();
            end
        end else if (mode_q != tlnorm_pkg::MODE_STREAM) begin
            blank_q = 1;
        end
        hold_n = 0;
        pend_sp = 0;
        mode_q = tlnorm_pkg::MODE_SKIP;
    endfunction

    function automatic void clear_stream();
        hold_n = 0;
        pend_sp = 0;
        mode_q = tlnorm_pkg::MODE_SKIP;
        blank_q = 0;
        wrote_q = 0;
        written_q = '0;
        ovf_q = 0;
    endfunction

    // Works out the results of one request and queues them.
    function automatic void predict_request(tlnorm_pkg::t_in_item it);
        tlnorm_pkg::t_out_item r;
        logic [7:0] b;
        b = it.data_byte;
        burst.delete();
        if (it.cmd == tlnorm_pkg::CMD_END) begin
            close_line();
            r = '0;
            r.kind = tlnorm_pkg::KIND_REPORT;
            r.status = ovf_q;
            r.total_length = written_q;
            burst.push_back(r);
            clear_stream();
        end else if (b == tlnorm_pkg::CH_NL) begin
            close_line();
        end else if (ws_char(b)) begin
            if (mode_q == tlnorm_pkg::MODE_HOLD) begin
                if (pend_sp < HOLD_LEN) pend_sp++;
            end else if (mode_q == tlnorm_pkg::MODE_STREAM) begin
                pend_sp = 1;
            end
        end else if (mode_q == tlnorm_pkg::MODE_HOLD) begin
            if (hold_n + pend_sp + 1 <= HOLD_LEN) begin
                while (pend_sp > 0) begin
                    hold_q[hold_n] = tlnorm_pkg::CH_SPACE;
                    hold_n++;
                    pend_sp--;
                end
                hold_q[hold_n] = b;
                hold_n++;
            end else begin
                // line grew past the hold: commit it and stream from here on
                open_content_line();
                flush_hold();
                if (pend_sp != 0) push_text(tlnorm_pkg::CH_SPACE);
                push_text(b);
                pend_sp = 0;
                hold_n = 0;
                mode_q = tlnorm_pkg::MODE_STREAM;
            end
        end else if (mode_q == tlnorm_pkg::MODE_STREAM) begin
            if (pend_sp != 0) push_text(tlnorm_pkg::CH_SPACE);
            push_text(b);
            pend_sp = 0;
        end else begin
            hold_q[0] = b;
            hold_n = 1;
            pend_sp = 0;
            mode_q = tlnorm_pkg::MODE_HOLD;
        end
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        foreach (burst[i]) expected_results.push_back(burst[i]);
    endfunction

    // ---------------------------------------------------------------
    // Result side: random stalls, compare each accepted result.
    // ---------------------------------------------------------------
    int stall_left = 0;
    always @(posedge i_clk) begin
        tlnorm_pkg::t_out_item exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out);
                n_errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_out !== exp_r) begin
                    $display("%0t: result mismatch expected %h actual %h", $time, exp_r, o_out);
                    n_errors++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                    : $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Request side.
    // ---------------------------------------------------------------
    bit calm = 0;   // phases without gaps

    // Valid stays up between back-to-back requests; it drops only for a gap or a drain.
    task automatic send_request(tlnorm_pkg::t_in_item it);
        int gap;
        gap = calm ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(4, 25)
                                                      : $urandom_range(0, 1));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_request(it);
        n_sent++;
    endtask

    task automatic send_data(logic [7:0] b);
        tlnorm_pkg::t_in_item it;
        it.cmd = tlnorm_pkg::CMD_DATA;
        it.data_byte = b;
        send_request(it);
    endtask

    task automatic send_end();
        tlnorm_pkg::t_in_item it;
        it.cmd = tlnorm_pkg::CMD_END;
        it.data_byte = 8'($urandom);
        send_request(it);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_data(s[i]);
    endtask

    // Waits for the queue to drain, then for the tail of any dropped-line work.
    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [24:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= tlnorm_pkg::ADDR_W'(4 * tlnorm_pkg::REG_CAPACITY);
        pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cap_q = v;
        @(posedge i_clk);
    endtask

    // Directed table; rows with cmd 1 are end items.
    tlnorm_pkg::t_in_item directed[N_DIRECTED] = '{
        '{tlnorm_pkg::CMD_END,  8'hFF},     // end right after reset: empty report
        '{tlnorm_pkg::CMD_DATA, 8'h20}, '{tlnorm_pkg::CMD_DATA, 8'h09},   // leading ws skipped
        '{tlnorm_pkg::CMD_DATA, 8'hFF}, '{tlnorm_pkg::CMD_DATA, 8'h0D},   // high byte held
        '{tlnorm_pkg::CMD_DATA, 8'h00}, '{tlnorm_pkg::CMD_DATA, 8'h0A},   // low byte, line end
        '{tlnorm_pkg::CMD_DATA, 8'h0A}, '{tlnorm_pkg::CMD_DATA, 8'h0B},   // blank line
        '{tlnorm_pkg::CMD_DATA, "P"},   '{tlnorm_pkg::CMD_DATA, "a"},
        '{tlnorm_pkg::CMD_DATA, "G"},   '{tlnorm_pkg::CMD_DATA, "e"},
        '{tlnorm_pkg::CMD_DATA, " "},   '{tlnorm_pkg::CMD_DATA, "7"},     // page line dropped
        '{tlnorm_pkg::CMD_DATA, 8'h0A},
        '{tlnorm_pkg::CMD_DATA, "1"},   '{tlnorm_pkg::CMD_DATA, "|"},
        '{tlnorm_pkg::CMD_DATA, "2"},   '{tlnorm_pkg::CMD_DATA, 8'h0A},   // number line dropped
        '{tlnorm_pkg::CMD_DATA, 8'h80}, '{tlnorm_pkg::CMD_DATA, 8'h0C},
        '{tlnorm_pkg::CMD_DATA, 8'h7F}, '{tlnorm_pkg::CMD_END,  8'h00}
    };

    // Random line content biased toward page numbers and whitespace.
    function automatic logic [7:0] rand_char(int flavor);
        case (flavor)
            0: return 8'($urandom_range("0", "9"));
            1: return ($urandom_range(0, 1)) ? " " : 8'h09;
            2: begin
                case ($urandom_range(0, 4))
                    0: return "-";
                    1: return "/";
                    2: return "|";
                    3: return ".";
                    default: return 8'h0B;
                endcase
            end
            3: return 8'($urandom);
            default: return 8'($urandom_range("a", "z"));
        endcase
    endfunction

    task automatic random_line();
        int len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1)) send_text("page ");
            else send_text("PaGe");
        end
        for (int i = 0; i < len; i++) send_data(rand_char($urandom_range(0, 5)));
        if ($urandom_range(0, 5) == 0) send_end();
        else send_data(tlnorm_pkg::CH_NL);
    endtask

    initial begin
        logic [24:0] caps[6] = '{25'd0, 25'd1, 25'd5, 25'd40, 25'h1FFFFFF, 25'd16777216};
        cap_q = tlnorm_pkg::CAP_RESET;
        clear_stream();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset capacity; the empty report is known outright.
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(directed[i]);
            if (i == 0 && (burst.size() != 1 || burst[0].kind != tlnorm_pkg::KIND_REPORT
                           || burst[0].total_length != 0 || burst[0].last != 1'b1)) begin
                $display("%0t: post-reset report expected %h actual %h", $time,
                         {tlnorm_pkg::KIND_REPORT, 8'h00, 1'b0, 24'd0, 1'b1}, burst[0]);
                n_errors++;
            end
        end
        drain();

        // Random part across several capacities, extremes included.
        foreach (caps[k]) begin
            write_capacity(caps[k]);
            calm = (k == 3);
            while (n_sent < N_DIRECTED + 33 * (k + 1)) begin
                random_line();
            end
            send_end();
            drain();   // sender holds off until every result is in
        end
        write_capacity(25'd4096);
        for (int i = 0; i < 30; i++) send_data(8'($urandom));
        send_end();
        drain();

        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/tlnorm_pkg.sv
rtl/tlnorm_ctrl.sv
rtl/tlnorm_dp.sv
rtl/text_line_normalizer_core.sv
tb/sv/tb_top.sv
